// ===== src/clock_page_replacement_top_defines.svh =====
// assertion macros for the clock page replacement block
`ifndef CLOCK_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define CPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define CPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CPR_ASSERT(lbl, prop, msg)
`define CPR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/cpr_pkg.sv =====
// shared types and constants of the clock page replacement block
`timescale 1ns / 1ps

package cpr_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned MAX_FRAMES  = 8;
  localparam int unsigned PAGE_SLOTS  = 256;
  localparam int unsigned PAGE_W      = 8;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned FRAME_W     = 3;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 2'd2;

  // replacement modes
  localparam logic MODE_CLOCK   = 1'b0;
  localparam logic MODE_CLOCK_M = 1'b1;

  // one page table entry
  typedef struct packed {
    logic               present;
    logic               referenced;
    logic               modified;
    logic [FRAME_W-1:0] frame;
  } pte_t;

  // access request to the page entry memory
  typedef struct packed {
    logic              re;
    logic [PAGE_W-1:0] raddr;
    logic              we;
    logic [PAGE_W-1:0] waddr;
    pte_t              wdata;
  } cpr_ram_req_t;

endpackage

// ===== src/clock_page_replacement_top.sv =====
// top level of the clock page replacement block
`timescale 1ns / 1ps
`include "clock_page_replacement_top_defines.svh"

// Page lookup and frame replacement for one process over a 256-entry page
// table held in a synchronous memory. One item is worked on at a time and
// the result goes to an output register, so the next item is taken while a
// result still waits. A bad index goes straight to the output register, a
// hit or a miss with a free frame first reads and updates its entry, and a
// miss that needs a victim sweeps with the clock hand, then installs. The
// sweep does one memory read-modify-write per cycle, at most n+1 steps for
// plain clock and 3n+1 for enhanced clock, n being the frames in use (at most 8).
// Reset needs no clearing pass; the memory tracks written entries itself.
module clock_page_replacement_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cpr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cpr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // access items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cpr_pkg::IDX_W-1:0]      outer_index_i,
  input  logic [cpr_pkg::IDX_W-1:0]      inner_index_i,
  input  logic                           is_write_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cpr_pkg::FRAME_W-1:0]    frame_number_o,
  output logic                           index_error_o,
  output logic                           page_fault_o,
  output logic                           victim_valid_o,
  output logic [cpr_pkg::PAGE_W-1:0]     victim_page_o,
  output logic                           victim_dirty_o,
  output logic                           swap_in_o
);
  import cpr_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LOOKUP  = 3'd1;
  localparam logic [2:0] S_SWEEP   = 3'd2;
  localparam logic [2:0] S_INSTALL = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [2:0]            state_q, state_d;
  logic                  mode_q;
  logic [3:0]            frames_cfg_q;
  logic [4:0]            entries_cfg_q;
  logic [PAGE_W-1:0]     page_q, page_d;
  logic                  wr_q, wr_d;
  logic [COUNT_W-1:0]    fiu_q, fiu_d;
  logic [FRAME_W-1:0]    hand_q, hand_d;
  logic [FRAME_W-1:0]    step_q, step_d;
  logic [1:0]            round_q, round_d;
  logic [PAGE_W-1:0]     resident_q [MAX_FRAMES];

  // result being built
  logic [FRAME_W-1:0]    frame_q, frame_d;
  logic                  err_q, err_d;
  logic                  fault_q, fault_d;
  logic                  vvalid_q, vvalid_d;
  logic [PAGE_W-1:0]     vpage_q, vpage_d;
  logic                  vdirty_q, vdirty_d;
  logic                  swin_q, swin_d;

  // output register
  logic                  out_valid_q;
  logic [FRAME_W-1:0]    out_frame_q;
  logic                  out_err_q;
  logic                  out_fault_q;
  logic                  out_vvalid_q;
  logic [PAGE_W-1:0]     out_vpage_q;
  logic                  out_vdirty_q;
  logic                  out_swin_q;
  logic                  out_load;

  cpr_ram_req_t          ram_req;
  pte_t                  entry;
  logic                  res_we;
  logic [FRAME_W-1:0]    res_waddr;
  logic [FRAME_W-1:0]    res_raddr;
  logic [PAGE_W-1:0]     res_rdata;

  logic [4:0]            idx_lim;
  logic [COUNT_W-1:0]    frame_lim;
  logic                  idx_bad;
  logic [FRAME_W-1:0]    hand_adj;
  logic [FRAME_W-1:0]    hand_nx;
  logic                  want_mod;
  logic                  found;

  cpr_entry_ram u_entry_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (ram_req),
    .rd_entry_o (entry)
  );

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_CLOCK;
      frames_cfg_q  <= 4'(MAX_FRAMES);
      entries_cfg_q <= 5'(MAX_ENTRIES);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MODE:    mode_q        <= cfg_data_i[0];
        REG_FRAMES:  frames_cfg_q  <= cfg_data_i[3:0];
        REG_ENTRIES: entries_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // limits derived from the configuration
  always_comb begin
    idx_lim = (entries_cfg_q > 5'(MAX_ENTRIES)) ? 5'(MAX_ENTRIES) : entries_cfg_q;
    idx_bad = ({1'b0, outer_index_i} >= idx_lim) || ({1'b0, inner_index_i} >= idx_lim);
    if (frames_cfg_q == 4'd0) begin
      frame_lim = 4'd1;
    end else if (frames_cfg_q > COUNT_W'(MAX_FRAMES)) begin
      frame_lim = COUNT_W'(MAX_FRAMES);
    end else begin
      frame_lim = frames_cfg_q;
    end
  end

  // clock hand helpers
  assign hand_adj  = ({1'b0, hand_q} >= fiu_q) ? '0 : hand_q;
  assign hand_nx   = (({1'b0, hand_q} + 4'd1) == fiu_q) ? '0 : hand_q + 3'd1;
  assign want_mod  = round_q[0];
  assign found     = (mode_q == MODE_CLOCK_M) ? (!entry.referenced && entry.modified == want_mod)
                                              : !entry.referenced;
  assign res_raddr = (state_q == S_LOOKUP) ? hand_adj : hand_nx;
  assign res_rdata = resident_q[res_raddr];

  assign in_stall_o = (state_q != S_IDLE);
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d   = state_q;
    page_d    = page_q;
    wr_d      = wr_q;
    fiu_d     = fiu_q;
    hand_d    = hand_q;
    step_d    = step_q;
    round_d   = round_q;
    frame_d   = frame_q;
    err_d     = err_q;
    fault_d   = fault_q;
    vvalid_d  = vvalid_q;
    vpage_d   = vpage_q;
    vdirty_d  = vdirty_q;
    swin_d    = swin_q;
    ram_req   = '0;
    res_we    = 1'b0;
    res_waddr = hand_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          page_d   = {outer_index_i, inner_index_i};
          wr_d     = is_write_i;
          frame_d  = '0;
          err_d    = idx_bad;
          fault_d  = 1'b0;
          vvalid_d = 1'b0;
          vpage_d  = '0;
          vdirty_d = 1'b0;
          swin_d   = 1'b0;
          if (idx_bad) begin
            state_d = S_EMIT;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = {outer_index_i, inner_index_i};
            state_d       = S_LOOKUP;
          end
        end
      end

      S_LOOKUP: begin
        if (entry.present) begin
          // hit: mark used, maybe modified
          ram_req.we    = 1'b1;
          ram_req.waddr = page_q;
          ram_req.wdata = '{present: 1'b1, referenced: 1'b1,
                            modified: entry.modified | wr_q, frame: entry.frame};
          frame_d       = entry.frame;
          state_d       = S_EMIT;
        end else begin
          fault_d = 1'b1;
          swin_d  = entry.modified;
          if (fiu_q < frame_lim) begin
            // free frame handed out
            frame_d       = fiu_q[FRAME_W-1:0];
            fiu_d         = fiu_q + 4'd1;
            res_we        = 1'b1;
            res_waddr     = fiu_q[FRAME_W-1:0];
            ram_req.we    = 1'b1;
            ram_req.waddr = page_q;
            ram_req.wdata = '{present: 1'b1, referenced: 1'b1,
                              modified: entry.modified | wr_q, frame: fiu_q[FRAME_W-1:0]};
            state_d       = S_EMIT;
          end else begin
            // start the sweep at the hand
            hand_d        = hand_adj;
            step_d        = '0;
            round_d       = '0;
            ram_req.re    = 1'b1;
            ram_req.raddr = res_rdata;
            state_d       = S_SWEEP;
          end
        end
      end

      S_SWEEP: begin
        if (found) begin
          // evict the page at the hand, keep its modified bit
          vvalid_d      = 1'b1;
          vpage_d       = ram_req.raddr;
          vdirty_d      = entry.modified;
          frame_d       = hand_q;
          hand_d        = hand_nx;
          res_we        = 1'b1;
          res_waddr     = hand_q;
          ram_req.we    = 1'b1;
          ram_req.waddr = resident_q[hand_q];
          ram_req.wdata = '{present: 1'b0, referenced: 1'b0,
                            modified: entry.modified, frame: entry.frame};
          vpage_d       = resident_q[hand_q];
          state_d       = S_INSTALL;
        end else begin
          // clear the use bit where this pass does so, then move on
          if (mode_q == MODE_CLOCK || want_mod) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = resident_q[hand_q];
            ram_req.wdata = '{present: entry.present, referenced: 1'b0,
                              modified: entry.modified, frame: entry.frame};
          end
          hand_d        = hand_nx;
          ram_req.re    = 1'b1;
          ram_req.raddr = res_rdata;
          if (({1'b0, step_q} + 4'd1) == fiu_q) begin
            step_d  = '0;
            round_d = round_q + 2'd1;
          end else begin
            step_d = step_q + 3'd1;
          end
        end
      end

      S_INSTALL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = page_q;
        ram_req.wdata = '{present: 1'b1, referenced: 1'b1,
                          modified: swin_q | wr_q, frame: frame_q};
        state_d       = S_EMIT;
      end

      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fiu_q   <= '0;
      hand_q  <= '0;
      step_q  <= '0;
      round_q <= '0;
    end else begin
      state_q <= state_d;
      fiu_q   <= fiu_d;
      hand_q  <= hand_d;
      step_q  <= step_d;
      round_q <= round_d;
    end
  end

  // item payload and result fields
  always_ff @(posedge clk_i) begin
    page_q   <= page_d;
    wr_q     <= wr_d;
    frame_q  <= frame_d;
    err_q    <= err_d;
    fault_q  <= fault_d;
    vvalid_q <= vvalid_d;
    vpage_q  <= vpage_d;
    vdirty_q <= vdirty_d;
    swin_q   <= swin_d;
    if (res_we) begin
      resident_q[res_waddr] <= page_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_frame_q  <= frame_q;
      out_err_q    <= err_q;
      out_fault_q  <= fault_q;
      out_vvalid_q <= vvalid_q;
      out_vpage_q  <= vpage_q;
      out_vdirty_q <= vdirty_q;
      out_swin_q   <= swin_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_number_o = out_frame_q;
  assign index_error_o  = out_err_q;
  assign page_fault_o   = out_fault_q;
  assign victim_valid_o = out_vvalid_q;
  assign victim_page_o  = out_vpage_q;
  assign victim_dirty_o = out_vdirty_q;
  assign swap_in_o      = out_swin_q;

  // checks
  `CPR_ASSERT(a_fiu_bound, (fiu_q <= COUNT_W'(MAX_FRAMES)), "frames in use beyond limit")
  `CPR_ASSERT(a_hand_range, ((fiu_q != '0) |-> ({1'b0, hand_q} < fiu_q)), "hand out of range")
  `CPR_ASSERT(a_sweep_frames, ((state_q == S_SWEEP) |-> (fiu_q != '0)), "sweep with no frames")
  `CPR_ASSERT(a_result_src, ($rose(out_valid_o) |-> $past(state_q == S_EMIT)), "stray result")
  `CPR_ASSERT_ALWAYS(a_reset_out, ((!rst_ni) |-> (out_valid_o !== 1'b1)), "result during reset")

endmodule

// ===== src/cpr_entry_ram.sv =====
// page entry memory with per-entry valid bits and write-to-read forwarding
`timescale 1ns / 1ps

module cpr_entry_ram (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cpr_pkg::cpr_ram_req_t req_i,
  output cpr_pkg::pte_t         rd_entry_o
);
  import cpr_pkg::*;

  pte_t              mem_q [PAGE_SLOTS];
  pte_t              rdata_q;
  logic [PAGE_SLOTS-1:0] valid_q;
  logic [PAGE_W-1:0] rd_addr_q;
  logic              fwd_q;
  pte_t              fwd_data_q;

  // storage array, read first
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  // entries never written read as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  // catch a write to the address read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      fwd_q     <= 1'b0;
    end else if (req_i.re) begin
      rd_addr_q <= req_i.raddr;
      fwd_q     <= req_i.we && (req_i.waddr == req_i.raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      fwd_data_q <= req_i.wdata;
    end
  end

  // read data select
  always_comb begin
    if (fwd_q) begin
      rd_entry_o = fwd_data_q;
    end else if (valid_q[rd_addr_q]) begin
      rd_entry_o = rdata_q;
    end else begin
      rd_entry_o = '0;
    end
  end

endmodule
